@@ sv/pif_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// pif_pkg: shared types for the integer field formatter
// Controller states, command/status structs and character constants.
// ---------------------------------------------------------------------------
package pif_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIGIT,
      ST_EMIT,
      ST_WAIT
   } state_type;

   typedef enum logic [2:0] {
      CV_SDEC  = 3'd0,
      CV_UDEC  = 3'd1,
      CV_OCT   = 3'd2,
      CV_HEX   = 3'd3,
      CV_UHEX  = 3'd4,
      CV_PTR   = 3'd5,
      CV_CHAR  = 3'd6,
      CV_NONE  = 3'd7
   } conv_type;

   typedef enum logic [2:0] {
      SEG_PAD_A,
      SEG_PRE,
      SEG_FILL,
      SEG_ZPAD,
      SEG_BODY,
      SEG_PAD_B,
      SEG_DONE
   } seg_type;

   typedef struct packed {
      logic load;       // capture request word
      logic digit_step; // produce one digit
      logic plan;       // compute layout
      logic emit_step;  // advance output pointer
   } cmd_type;

   typedef struct packed {
      logic invalid;    // unused conversion
      logic digits_done;
      logic emit_done;  // pointer passed last char
   } sts_type;

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_MINUS = 8'h2D;

   function automatic logic [7:0] hex_char(input logic [3:0] d, input logic upper);
      logic [7:0] c;
      if (d < 4'd10) c = 8'h30 + {4'd0, d};
      else if (upper) c = 8'h37 + {4'd0, d};
      else c = 8'h57 + {4'd0, d};
      return c;
   endfunction

   function automatic logic [7:0] nil_char(input logic [2:0] i);
      logic [7:0] c;
      unique case (i)
         3'd0: c = 8'h28;
         3'd1: c = 8'h6E;
         3'd2: c = 8'h69;
         3'd3: c = 8'h6C;
         default: c = 8'h29;
      endcase
      return c;
   endfunction

endpackage
`default_nettype wire

@@ sv/pif_datapath.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// pif_datapath: digit generation and character sequencing
// Holds the request, builds digits one per cycle and walks the field layout.
// ---------------------------------------------------------------------------
module pif_datapath #(
   parameter int MAX_FIELD     = 64,
   parameter int MAX_PRECISION = 60,
   parameter int DIGIT_BUFFER  = 32
) (
   input  wire logic             clock,
   input  wire pif_pkg::cmd_type cmd,
   output pif_pkg::sts_type      sts,
   input  wire logic [63:0]      req_value,
   input  wire logic [2:0]       req_conversion,
   input  wire logic             req_wide_arg,
   input  wire logic             req_left_align,
   input  wire logic             req_pad_zero,
   input  wire logic             req_alt_form,
   input  wire logic             req_has_precision,
   input  wire logic [6:0]       req_field_width,
   input  wire logic [5:0]       req_precision_value,
   output logic [7:0]            out_char,
   output logic                  last_char
);
   localparam int BW = $clog2(DIGIT_BUFFER + 1);
   localparam int IW = $clog2(DIGIT_BUFFER);
   localparam int FW = $clog2(MAX_FIELD + 1);
   localparam int PW = $clog2(MAX_PRECISION + 1);
   localparam int CW = 8;
   localparam int DABBLE_STEPS = 64;

   // digit buffer; digits stored least significant first
   logic [7:0] digit_ff [DIGIT_BUFFER];

   logic [63:0]     mag_ff, mag_in;
   logic [79:0]     bcd_ff, bcd_in;
   logic [6:0]      dab_ff, dab_in;
   logic            dec_ff;
   pif_pkg::conv_type conv_ff;
   logic            left_ff, zpad_ff, alt_ff, hasp_ff, neg_ff, text_ff, nil_ff;
   logic [7:0]      cbyte_ff;
   logic [FW-1:0]   fw_ff;
   logic [PW-1:0]   prec_ff;
   logic [BW-1:0]   blen_ff;
   logic            zskip_ff;
   logic [CW-1:0]   fill_ff, pad_ff;
   logic [1:0]      plen_ff;
   logic [7:0]      pre0_ff, pre1_ff;
   pif_pkg::seg_type seg_ff, seg_in;
   logic [CW-1:0]   cnt_ff, cnt_in;

   logic [63:0] v_ext, v_abs;
   logic        v_neg;
   logic [3:0]  dig;
   logic [63:0] mag_div;
   logic [7:0]  dig_ch;
   logic [79:0] bcd_adj;
   logic        dab_done;
   logic        dwrite;

   always_comb begin
      v_ext = req_value;
      if (!req_wide_arg && req_conversion != pif_pkg::CV_PTR) begin
         v_ext = {32'd0, req_value[31:0]};
         if (req_conversion == pif_pkg::CV_SDEC && req_value[31])
            v_ext = {32'hFFFF_FFFF, req_value[31:0]};
      end
      v_neg = (req_conversion == pif_pkg::CV_SDEC) && v_ext[63];
      v_abs = v_neg ? (64'd0 - v_ext) : v_ext;
   end

   // octal and hex shift digits out; decimal reads them from the BCD register
   always_comb begin
      dig     = bcd_ff[3:0];
      mag_div = mag_ff;
      unique case (conv_ff)
         pif_pkg::CV_OCT: begin
            dig = {1'b0, mag_ff[2:0]};
            mag_div = mag_ff >> 3;
         end
         pif_pkg::CV_HEX, pif_pkg::CV_UHEX, pif_pkg::CV_PTR: begin
            dig = mag_ff[3:0];
            mag_div = mag_ff >> 4;
         end
         default: ;
      endcase
      dig_ch = pif_pkg::hex_char(dig, conv_ff == pif_pkg::CV_UHEX);
   end

   // shift-and-add-3 binary to decimal, one bit per step
   always_comb begin
      for (int j = 0; j < 20; j++)
         bcd_adj[4*j +: 4] = (bcd_ff[4*j +: 4] >= 4'd5) ? bcd_ff[4*j +: 4] + 4'd3
                                                        : bcd_ff[4*j +: 4];
   end

   assign dab_done = dab_ff == 7'(DABBLE_STEPS);

   logic [BW-1:0] blen_in;
   always_comb begin
      mag_in  = mag_ff;
      blen_in = blen_ff;
      bcd_in  = bcd_ff;
      dab_in  = dab_ff;
      dwrite  = 1'b0;
      if (cmd.digit_step) begin
         if (!dab_done) begin
            bcd_in = {bcd_adj[78:0], mag_ff[63]};
            mag_in = {mag_ff[62:0], 1'b0};
            dab_in = dab_ff + 7'd1;
         end else begin
            if (dec_ff) bcd_in = {4'd0, bcd_ff[79:4]};
            else mag_in = mag_div;
            blen_in = blen_ff + BW'(1);
            dwrite  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mag_ff   <= v_abs;
         bcd_ff   <= '0;
         dec_ff   <= req_conversion == pif_pkg::CV_SDEC
                     || req_conversion == pif_pkg::CV_UDEC;
         dab_ff   <= (req_conversion == pif_pkg::CV_SDEC
                     || req_conversion == pif_pkg::CV_UDEC) ? 7'd0 : 7'(DABBLE_STEPS);
         conv_ff  <= pif_pkg::conv_type'(req_conversion);
         left_ff  <= req_left_align;
         zpad_ff  <= req_pad_zero;
         alt_ff   <= req_alt_form;
         hasp_ff  <= req_has_precision;
         neg_ff   <= v_neg;
         nil_ff   <= req_conversion == pif_pkg::CV_PTR && req_value == 64'd0;
         text_ff  <= req_conversion == pif_pkg::CV_CHAR
                     || (req_conversion == pif_pkg::CV_PTR && req_value == 64'd0);
         cbyte_ff <= req_value[7:0];
         fw_ff    <= (req_field_width > 7'(MAX_FIELD)) ? FW'(MAX_FIELD)
                                                       : FW'(req_field_width);
         prec_ff  <= (req_precision_value > 6'(MAX_PRECISION)) ? PW'(MAX_PRECISION)
                                                               : PW'(req_precision_value);
         zskip_ff <= req_has_precision && req_precision_value == 6'd0
                     && v_abs == 64'd0;
         blen_ff  <= '0;
      end else begin
         mag_ff  <= mag_in;
         bcd_ff  <= bcd_in;
         dab_ff  <= dab_in;
         blen_ff <= blen_in;
      end
      if (dwrite)
         digit_ff[blen_ff[IW-1:0]] <= dig_ch;
   end

   assign sts.invalid = conv_ff == pif_pkg::CV_NONE;
   assign sts.digits_done = text_ff || zskip_ff
      || (dab_done && blen_ff != '0
          && ((dec_ff ? bcd_ff == 80'd0 : mag_ff == 64'd0)
              || blen_ff == BW'(DIGIT_BUFFER)));

   // layout plan
   logic [CW-1:0] blen_eff, fill_c, plen_c, total_c, pad_c;
   logic [1:0]    plen2;
   logic [7:0]    p0, p1;
   logic          zp;
   always_comb begin
      fill_c = '0;
      plen2  = 2'd0;
      p0     = pif_pkg::CH_ZERO;
      p1     = 8'h78;
      zp     = zpad_ff && !hasp_ff;
      if (text_ff) begin
         blen_eff = nil_ff ? CW'(5) : CW'(1);
         if (hasp_ff) begin
            if (CW'(prec_ff) < blen_eff) blen_eff = CW'(prec_ff);
         end
      end else begin
         blen_eff = zskip_ff ? '0 : CW'(blen_ff);
         if (hasp_ff && CW'(prec_ff) > blen_eff) fill_c = CW'(prec_ff) - blen_eff;
         if (neg_ff) begin
            plen2 = 2'd1;
            p0    = pif_pkg::CH_MINUS;
         end else if (conv_ff == pif_pkg::CV_OCT && alt_ff) begin
            if (fill_c == '0 && (blen_eff == '0
                || digit_ff[IW'(blen_ff - BW'(1))] != pif_pkg::CH_ZERO))
               plen2 = 2'd1;
         end else if (conv_ff == pif_pkg::CV_PTR || (alt_ff && !zskip_ff
                  && (conv_ff == pif_pkg::CV_HEX || conv_ff == pif_pkg::CV_UHEX)
                  && !(blen_ff == BW'(1) && digit_ff[0] == pif_pkg::CH_ZERO))) begin
            plen2 = 2'd2;
            if (conv_ff == pif_pkg::CV_UHEX) p1 = 8'h58;
         end
      end
      plen_c  = CW'(plen2);
      total_c = plen_c + fill_c + blen_eff;
      pad_c   = (CW'(fw_ff) > total_c) ? CW'(fw_ff) - total_c : '0;
   end

   // body length latched at plan time for emission
   logic [CW-1:0] body_ff;
   logic          zp_ff;

   function automatic logic [CW-1:0] seg_len(input pif_pkg::seg_type s,
      input logic [CW-1:0] pa, input logic [CW-1:0] pl, input logic [CW-1:0] fi,
      input logic [CW-1:0] bo, input logic l, input logic z);
      logic [CW-1:0] n;
      unique case (s)
         pif_pkg::SEG_PAD_A: n = (l || z) ? '0 : pa;
         pif_pkg::SEG_PRE:   n = pl;
         pif_pkg::SEG_FILL:  n = fi;
         pif_pkg::SEG_ZPAD:  n = (z && !l) ? pa : '0;
         pif_pkg::SEG_BODY:  n = bo;
         pif_pkg::SEG_PAD_B: n = l ? pa : '0;
         default:            n = '0;
      endcase
      return n;
   endfunction

   // first segment after s that has chars
   function automatic pif_pkg::seg_type next_seg(input pif_pkg::seg_type s,
      input logic [CW-1:0] pa, input logic [CW-1:0] pl, input logic [CW-1:0] fi,
      input logic [CW-1:0] bo, input logic l, input logic z);
      pif_pkg::seg_type t;
      t = pif_pkg::SEG_DONE;
      for (int k = 5; k >= 0; k--)
         if (3'(k) > s
             && seg_len(pif_pkg::seg_type'(3'(k)), pa, pl, fi, bo, l, z) != '0)
            t = pif_pkg::seg_type'(3'(k));
      return t;
   endfunction

   // layout: PAD_A PRE FILL ZPAD BODY PAD_B; empty segments are skipped
   logic [CW-1:0]    cur_len;
   pif_pkg::seg_type after_seg;
   logic             last_c;
   always_comb begin
      cur_len   = seg_len(seg_ff, pad_ff, CW'(plen_ff), fill_ff, body_ff, left_ff, zp_ff);
      after_seg = next_seg(seg_ff, pad_ff, CW'(plen_ff), fill_ff, body_ff, left_ff, zp_ff);
      seg_in    = seg_ff;
      cnt_in    = cnt_ff;
      if (cmd.plan) begin
         if (seg_len(pif_pkg::SEG_PAD_A, pad_c, plen_c, fill_c, blen_eff, left_ff, zp)
             != '0)
            seg_in = pif_pkg::SEG_PAD_A;
         else
            seg_in = next_seg(pif_pkg::SEG_PAD_A, pad_c, plen_c, fill_c, blen_eff,
                              left_ff, zp);
         cnt_in = '0;
      end else if (cmd.emit_step) begin
         if (cnt_ff + CW'(1) < cur_len) begin
            cnt_in = cnt_ff + CW'(1);
         end else begin
            seg_in = after_seg;
            cnt_in = '0;
         end
      end
      last_c = (cnt_ff + CW'(1) >= cur_len) && after_seg == pif_pkg::SEG_DONE;
   end

   always_ff @(posedge clock) begin
      seg_ff <= seg_in;
      cnt_ff <= cnt_in;
      if (cmd.plan) begin
         fill_ff <= fill_c;
         pad_ff  <= pad_c;
         plen_ff <= plen2;
         pre0_ff <= p0;
         pre1_ff <= p1;
         body_ff <= blen_eff;
         zp_ff   <= zp;
      end
   end

   logic [IW-1:0] bidx;
   always_comb begin
      bidx = IW'(CW'(blen_ff) - CW'(1) - cnt_ff);
      unique case (seg_ff)
         pif_pkg::SEG_PRE:  out_char = (cnt_ff == '0) ? pre0_ff : pre1_ff;
         pif_pkg::SEG_FILL, pif_pkg::SEG_ZPAD: out_char = pif_pkg::CH_ZERO;
         pif_pkg::SEG_BODY: begin
            if (nil_ff) out_char = pif_pkg::nil_char(cnt_ff[2:0]);
            else if (text_ff) out_char = cbyte_ff;
            else out_char = digit_ff[bidx];
         end
         default: out_char = pif_pkg::CH_SPACE;
      endcase
   end

   assign last_char     = last_c;
   assign sts.emit_done = seg_ff == pif_pkg::SEG_DONE;

endmodule
`default_nettype wire

@@ sv/pif_control.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// pif_control: conversion sequencer
// Accepts a word, runs digit steps, then emits characters with a one-word
// output register.
// ---------------------------------------------------------------------------
module pif_control (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output pif_pkg::cmd_type      cmd,
   input  wire pif_pkg::sts_type sts,
   input  wire logic [7:0]       char_in,
   input  wire logic             last_in,
   output logic [7:0]            rsp_out_char,
   output logic                  rsp_last_char
);
   pif_pkg::state_type state_ff, state_in;
   logic       ov_ff;
   logic       take;
   logic [7:0] ch_ff;
   logic       last_ff;

   assign take = !ov_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pif_pkg::ST_IDLE:  if (req_valid) state_in = pif_pkg::ST_DIGIT;
         pif_pkg::ST_DIGIT: begin
            if (sts.invalid) state_in = pif_pkg::ST_IDLE;
            else if (sts.digits_done) state_in = pif_pkg::ST_WAIT;
         end
         pif_pkg::ST_WAIT:  state_in = pif_pkg::ST_EMIT;
         pif_pkg::ST_EMIT:  if (sts.emit_done) state_in = pif_pkg::ST_IDLE;
         default:           state_in = pif_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         pif_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         pif_pkg::ST_DIGIT: begin
            cmd.digit_step = !sts.digits_done && !sts.invalid;
            cmd.plan       = sts.digits_done && !sts.invalid;
         end
         pif_pkg::ST_EMIT:  cmd.emit_step = !sts.emit_done && take;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pif_pkg::ST_IDLE;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.emit_step) ov_ff <= 1'b1;
         else if (!rsp_stall) ov_ff <= 1'b0;
      end
      if (cmd.emit_step) begin
         ch_ff   <= char_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid     = ov_ff;
   assign rsp_out_char  = ch_ff;
   assign rsp_last_char = last_ff;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_char))
      else $error("output word dropped under stall");
   a_idle_accept: assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> state_ff == pif_pkg::ST_IDLE)
      else $error("request taken while busy");
   a_step_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.digit_step && cmd.emit_step))
      else $error("digit and emit overlap");
endmodule
`default_nettype wire

@@ sv/printf_integer_field_formatter.sv @@
`default_nettype none
// Sequence: after a request is taken, the sequencer runs the binary-to-decimal
// shifts (d/i and u only), then a digit step per digit, plans the layout and emits.
// Conversions are not overlapped: a new request is taken only when the sequencer
// is idle again; the output register holds its word while rsp_stall is high.
// Reset: synchronous, active high; returns the sequencer to idle, no word out.
// ---------------------------------------------------------------------------
// printf_integer_field_formatter: formats one integer conversion as ASCII
// Controller plus datapath, one character per output word.
// ---------------------------------------------------------------------------
module printf_integer_field_formatter #(
   parameter int MAX_FIELD     = 64,
   parameter int MAX_PRECISION = 60,
   parameter int DIGIT_BUFFER  = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [63:0] req_value,
   input  wire logic [2:0]  req_conversion,
   input  wire logic        req_wide_arg,
   input  wire logic        req_left_align,
   input  wire logic        req_pad_zero,
   input  wire logic        req_alt_form,
   input  wire logic        req_has_precision,
   input  wire logic [6:0]  req_field_width,
   input  wire logic [5:0]  req_precision_value,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_out_char,
   output logic             rsp_last_char
);
   pif_pkg::cmd_type cmd;
   pif_pkg::sts_type sts;
   logic [7:0] ch;
   logic       lst;

   pif_datapath #(
      .MAX_FIELD(MAX_FIELD), .MAX_PRECISION(MAX_PRECISION),
      .DIGIT_BUFFER(DIGIT_BUFFER)
   ) u_dp (
      .clock, .cmd, .sts, .req_value, .req_conversion, .req_wide_arg,
      .req_left_align, .req_pad_zero, .req_alt_form, .req_has_precision,
      .req_field_width, .req_precision_value, .out_char(ch), .last_char(lst)
   );

   pif_control u_ctl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .cmd, .sts, .char_in(ch), .last_in(lst), .rsp_out_char, .rsp_last_char
   );
endmodule
`default_nettype wire
